// ===== hdl/tcr_pkg.sv =====
package tcr_pkg;

  // Default maximum token length in bytes
  localparam int unsigned MAX_TOKEN_LEN_DEF = 1024;

  // Result field widths
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned LEN_W   = 11;

  // Character codes used by the recognizers
  localparam logic [7:0] CH_NUL    = 8'd0;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_BAR    = 8'd124;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE = 2'd0,
    CLS_FP   = 2'd1,
    CLS_STR  = 2'd2,
    CLS_INT  = 2'd3
  } tok_class_t;

  typedef enum logic [2:0] {
    FP_START = 3'd0,
    FP_INT1  = 3'd1,
    FP_CLOSE = 3'd2,
    FP_OPEN  = 3'd3,
    FP_INT2  = 3'd4,
    FP_DEAD  = 3'd5
  } fp_state_t;

  typedef enum logic [1:0] {
    STR_START = 2'd0,
    STR_BODY  = 2'd1,
    STR_DONE  = 2'd2,
    STR_DEAD  = 2'd3
  } str_state_t;

  typedef enum logic [1:0] {
    INT_START = 2'd0,
    INT_HASH  = 2'd1,
    INT_BODY  = 2'd2,
    INT_DEAD  = 2'd3
  } int_state_t;

  // Input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [CLASS_W-1:0] token_class;
    logic [LEN_W-1:0]   token_length;
  } out_word_t;

  // Character classes
  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'd65) && (c <= 8'd90);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == CH_SPACE);
  endfunction

  // '0'-'9', 'r'-'w', 'R'-'W'
  function automatic logic is_int_body(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'd114) && (c <= 8'd119)) ||
           ((c >= 8'd82) && (c <= 8'd87));
  endfunction

endpackage

// ===== hdl/token_class_recognizer.sv =====
// Channel  | ports                        | word
// ---------+------------------------------+-------------------------------------
// input    | in_valid, in_ready, in_data  | in_byte[7:0], end_of_input
// result   | out_valid, out_ready, out_data | token_class[1:0], token_length[10:0]
//
// One byte is taken per cycle while in_ready is high; the three recognizer
// automata and the length counter step in the cycle the byte is accepted, and a
// completed token is registered (output register, or skid entry on a stall).
// Results pass through an output register plus a one-entry skid buffer, so
// input keeps flowing while the result side stalls until a second token
// completes; in_ready drops only while the skid entry is occupied.
// Reset (rst_n low, synchronous) returns all automata to their start state
// and empties both result entries.
module token_class_recognizer
  import tcr_pkg::*;
#(
  parameter int unsigned MAX_TOKEN_LEN = MAX_TOKEN_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int unsigned CNT_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TOKEN_LEN);

  // token state
  fp_state_t        fp_r,   fp_nxt;
  str_state_t       str_r,  str_nxt;
  int_state_t       int_r,  int_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic             zero_r, zero_nxt;

  // result buffers
  logic      out_valid_r, skid_valid_r;
  out_word_t out_r, skid_r;

  logic       in_fire;
  logic       res_valid;
  out_word_t  res_word;
  logic [7:0] c;
  logic       zero_now;
  logic       match_en;
  fp_state_t  fp_step;
  str_state_t str_step;
  int_state_t int_step;
  tok_class_t cls;
  logic [CNT_W-1:0] cnt_inc;
  logic [CNT_W-1:0] emit_len;
  logic [31:0]      emit_len_w;

  assign in_ready  = !skid_valid_r;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign c        = in_data.in_byte;
  assign zero_now = zero_r || (c == CH_NUL);
  assign match_en = !zero_now;
  assign cnt_inc  = cnt_r + 1'b1;

  // FP automaton step
  always_comb begin
    case (fp_r)
      FP_START: fp_step = is_digit(c) ? FP_INT1 : FP_DEAD;
      FP_INT1: begin
        if (is_digit(c))          fp_step = FP_INT1;
        else if (c == CH_RPAREN)  fp_step = FP_CLOSE;
        else                      fp_step = FP_DEAD;
      end
      FP_CLOSE: fp_step = (c == CH_LPAREN) ? FP_OPEN : FP_DEAD;
      FP_OPEN,
      FP_INT2:  fp_step = is_digit(c) ? FP_INT2 : FP_DEAD;
      default:  fp_step = FP_DEAD;
    endcase
  end

  // STR automaton step
  always_comb begin
    case (str_r)
      STR_START: str_step = (c == CH_BAR) ? STR_BODY : STR_DEAD;
      STR_BODY: begin
        if (is_upper(c) || is_digit(c)) str_step = STR_BODY;
        else if (c == CH_PLUS)          str_step = STR_DONE;
        else                            str_step = STR_DEAD;
      end
      default: str_step = STR_DEAD;
    endcase
  end

  // INT automaton step
  always_comb begin
    case (int_r)
      INT_START: int_step = (c == CH_HASH) ? INT_HASH : INT_DEAD;
      INT_HASH,
      INT_BODY:  int_step = is_int_body(c) ? INT_BODY : INT_DEAD;
      default:   int_step = INT_DEAD;
    endcase
  end

  // next token state and result
  always_comb begin
    fp_nxt    = fp_r;
    str_nxt   = str_r;
    int_nxt   = int_r;
    cnt_nxt   = cnt_r;
    zero_nxt  = zero_r;
    res_valid = 1'b0;
    emit_len  = cnt_r;
    if (in_fire) begin
      if (in_data.end_of_input || is_space(c)) begin
        // delimiter: finish pending token, if any; automata hold their
        // state here so the class reflects the bytes seen so far, and the
        // state registers clear on the completed token
        res_valid = (cnt_r != '0);
      end else begin
        if (match_en) begin
          fp_nxt  = fp_step;
          str_nxt = str_step;
          int_nxt = int_step;
        end
        zero_nxt = zero_now;
        cnt_nxt  = cnt_inc;
        emit_len = cnt_inc;
        // token reaches maximum length
        if (cnt_inc >= CNT_MAX) begin
          res_valid = 1'b1;
        end
      end
    end
  end

  // classify from the post-step automata, priority FP, STR, INT
  always_comb begin
    if (fp_nxt == FP_INT2)         cls = CLS_FP;
    else if (str_nxt == STR_DONE)  cls = CLS_STR;
    else if (int_nxt == INT_BODY)  cls = CLS_INT;
    else                           cls = CLS_NONE;
  end

  assign emit_len_w            = 32'(emit_len);
  assign res_word.token_class  = cls;
  assign res_word.token_length = emit_len_w[LEN_W-1:0];

  // token state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fp_r   <= FP_START;
      str_r  <= STR_START;
      int_r  <= INT_START;
      cnt_r  <= '0;
      zero_r <= 1'b0;
    end else begin
      // a completed token clears the automata for the next byte
      if (res_valid) begin
        fp_r   <= FP_START;
        str_r  <= STR_START;
        int_r  <= INT_START;
        cnt_r  <= '0;
        zero_r <= 1'b0;
      end else begin
        fp_r   <= fp_nxt;
        str_r  <= str_nxt;
        int_r  <= int_nxt;
        cnt_r  <= cnt_nxt;
        zero_r <= zero_nxt;
      end
    end
  end

  // output register and skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_valid_r && !out_ready) begin
      // output stalled: park new word in skid
      if (res_valid) begin
        skid_valid_r <= 1'b1;
      end
    end else if (skid_valid_r) begin
      out_valid_r  <= 1'b1;
      skid_valid_r <= res_valid;
    end else begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && !out_ready) begin
      if (res_valid) begin
        skid_r <= res_word;
      end
    end else if (skid_valid_r) begin
      out_r <= skid_r;
      if (res_valid) begin
        skid_r <= res_word;
      end
    end else if (res_valid) begin
      out_r <= res_word;
    end
  end

`ifndef SYNTHESIS
  // skid entry only fills behind a held output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // pending length never reaches the maximum
  a_cnt_below_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_MAX)
    else $error("pending token length reached maximum");

  // a zero byte is only ever recorded inside a pending token
  a_zero_in_token: assert property (@(posedge clk) disable iff (!rst_n)
    zero_r |-> (cnt_r != '0))
    else $error("zero-byte flag set with no pending token");

  // FP and STR accept disjoint first characters
  a_fp_str_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !((fp_r == FP_INT2) && (str_r == STR_DONE)))
    else $error("FP and STR both accepting");

  // end marker always leaves automata at start
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.end_of_input) |=> (cnt_r == '0) && (fp_r == FP_START))
    else $error("end marker did not clear token state");
`endif

endmodule
